[src/quad_area_perimeter_angles_unit_assert.svh]
// Assertion macros shared by the quadrilateral measurement unit.
`ifndef QUAD_AREA_PERIMETER_ANGLES_UNIT_ASSERT_SVH
`define QUAD_AREA_PERIMETER_ANGLES_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QAPA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qapa: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define QAPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qapa: next-cycle check failed");

`endif

[src/qapa_pkg.sv]
// Shared widths, pipeline depths and the arctangent table of the unit.
`default_nettype none
package qapa_pkg;
  localparam int COORD_W = 16;
  localparam int DELTA_W = COORD_W + 1;
  localparam int PROD_W = 2 * DELTA_W;
  localparam int AREA_PROD_W = 2 * COORD_W;
  localparam int AREA_W = 2 * COORD_W + 3;
  localparam int SUMSQ_W = PROD_W;
  localparam int DOT_W = PROD_W + 2;
  localparam int FRAC_BITS = 8;
  localparam int ANG_FRAC = 16;
  localparam int SQRT_STEPS = 25;
  localparam int SQ_IN_W = 2 * SQRT_STEPS;
  localparam int ROOT_W = 25;
  localparam int REM_W = 28;
  localparam int PERIM_W = 27;
  localparam int CORDIC_N = 22;
  localparam int PRESCALE = 56 - 2 * COORD_W;
  localparam int CV_W = 62;
  localparam int Z_W = 26;
  localparam int ANGLE_W = 16;
  localparam int ANGLE_MAX = 180 << FRAC_BITS;
  localparam int SQRT_LAT = SQRT_STEPS + 1;
  localparam int CORDIC_LAT = CORDIC_N + 2;
  localparam int ANG_DLY = SQRT_LAT - CORDIC_LAT;
  localparam int NSTAGE = 4 + SQRT_LAT + 1;

  function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
    logic signed [Z_W-1:0] t;
    unique case (idx)
      5'd0: t = 26'sd2949120;
      5'd1: t = 26'sd1740967;
      5'd2: t = 26'sd919879;
      5'd3: t = 26'sd466945;
      5'd4: t = 26'sd234379;
      5'd5: t = 26'sd117306;
      5'd6: t = 26'sd58666;
      5'd7: t = 26'sd29335;
      5'd8: t = 26'sd14668;
      5'd9: t = 26'sd7334;
      5'd10: t = 26'sd3667;
      5'd11: t = 26'sd1833;
      5'd12: t = 26'sd917;
      5'd13: t = 26'sd458;
      5'd14: t = 26'sd229;
      5'd15: t = 26'sd115;
      5'd16: t = 26'sd57;
      5'd17: t = 26'sd29;
      5'd18: t = 26'sd14;
      5'd19: t = 26'sd7;
      5'd20: t = 26'sd4;
      5'd21: t = 26'sd2;
      default: t = '0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

[src/qapa_if.sv]
// Valid/ready channel interfaces for input vertices and result items.
`default_nettype none
interface qapa_in_if;
  import qapa_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] vertex1_x, vertex1_y, vertex2_x, vertex2_y;
  logic signed [COORD_W-1:0] vertex3_x, vertex3_y, vertex4_x, vertex4_y;
  modport source(output valid, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
                 vertex3_x, vertex3_y, vertex4_x, vertex4_y, input ready);
  modport sink(input valid, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
               vertex3_x, vertex3_y, vertex4_x, vertex4_y, output ready);
endinterface

interface qapa_out_if;
  import qapa_pkg::*;
  logic valid;
  logic ready;
  logic signed [AREA_W-1:0] doubled_area;
  logic [PERIM_W-1:0] perimeter_q8;
  logic [ANGLE_W-1:0] angle_one_q8, angle_two_q8, angle_three_q8, angle_four_q8;
  logic degenerate;
  modport source(output valid, doubled_area, perimeter_q8, angle_one_q8, angle_two_q8,
                 angle_three_q8, angle_four_q8, degenerate, input ready);
  modport sink(input valid, doubled_area, perimeter_q8, angle_one_q8, angle_two_q8,
               angle_three_q8, angle_four_q8, degenerate, output ready);
endinterface
`default_nettype wire

[src/quad_area_perimeter_angles_unit.sv]
// Top level of the quadrilateral area, perimeter and inner angle unit.
//
// An item on din carries the four vertices of a quadrilateral, taken in
// order around it. For every accepted item the unit presents exactly one
// item on dout: twice the signed shoelace area, the perimeter in Q.8, the
// four inner angles in degrees, Q.8, and a flag for a zero-length side.
// The pipeline holds 31 register stages. While dout is not stalled, a new
// item can be accepted in every cycle; the depth is set by the 25
// bit-per-stage square root steps, with the 22 rotation steps of the angle
// lanes running beside them. While dout holds a result that is not taken,
// the whole pipeline holds and din.ready is low; nothing is lost or repeated.
// The output register is the last stage, so din.ready stays high as long as
// dout is taken or empty. Reset clears all valid bits; data registers are
// not reset.
`default_nettype none
module quad_area_perimeter_angles_unit (
  input  logic        clk,
  input  logic        rst,
  qapa_in_if.sink     din,
  qapa_out_if.source  dout
);
  import qapa_pkg::*;

  logic en;
  logic vld [0:NSTAGE-1];

  logic signed [COORD_W-1:0] a_x [0:3];
  logic signed [COORD_W-1:0] a_y [0:3];
  logic signed [DELTA_W-1:0] b_dx [0:3];
  logic signed [DELTA_W-1:0] b_dy [0:3];
  logic signed [AREA_PROD_W-1:0] b_pa [0:3];
  logic signed [AREA_PROD_W-1:0] b_pb [0:3];
  logic signed [PROD_W-1:0] c_sqx [0:3];
  logic signed [PROD_W-1:0] c_sqy [0:3];
  logic signed [PROD_W-1:0] c_pxx [0:3];
  logic signed [PROD_W-1:0] c_pyy [0:3];
  logic signed [PROD_W-1:0] c_pxy [0:3];
  logic signed [PROD_W-1:0] c_pyx [0:3];
  logic [3:0] c_zero;
  logic signed [AREA_W-1:0] c_area, area_sum;
  logic [SUMSQ_W-1:0] d_sumsq [0:3];
  logic signed [DOT_W-1:0] d_dot [0:3];
  logic signed [DOT_W-1:0] d_crs [0:3];
  logic [3:0] d_amask;
  logic d_degen;
  logic signed [AREA_W-1:0] d_area;
  logic signed [AREA_W-1:0] area_dl [1:SQRT_LAT];
  logic degen_dl [1:SQRT_LAT];
  logic [ROOT_W-1:0] root [0:3];
  logic [ANGLE_W-1:0] ang_fin [0:3];

  assign en = !vld[NSTAGE-1] || dout.ready;
  assign din.ready = en;
  assign dout.valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSTAGE; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= din.valid;
      for (int k = 1; k < NSTAGE; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x[0] <= din.vertex1_x;
      a_y[0] <= din.vertex1_y;
      a_x[1] <= din.vertex2_x;
      a_y[1] <= din.vertex2_y;
      a_x[2] <= din.vertex3_x;
      a_y[2] <= din.vertex3_y;
      a_x[3] <= din.vertex4_x;
      a_y[3] <= din.vertex4_y;
    end
  end

  always_comb begin
    area_sum = '0;
    for (int k = 0; k < 4; k++) begin
      area_sum = area_sum + AREA_W'(b_pa[k]) - AREA_W'(b_pb[k]);
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    localparam int NX = (i + 1) % 4;
    localparam int PV = (i + 3) % 4;
    logic [ANGLE_W-1:0] ang;
    logic [ANGLE_W-1:0] ang_dl [1:ANG_DLY];
    logic mask_dl [1:SQRT_LAT];

    always_ff @(posedge clk) begin
      if (en) begin
        b_dx[i] <= DELTA_W'(a_x[NX]) - DELTA_W'(a_x[i]);
        b_dy[i] <= DELTA_W'(a_y[NX]) - DELTA_W'(a_y[i]);
        b_pa[i] <= a_x[i] * a_y[NX];
        b_pb[i] <= a_x[NX] * a_y[i];
        c_sqx[i] <= b_dx[i] * b_dx[i];
        c_sqy[i] <= b_dy[i] * b_dy[i];
        c_pxx[i] <= b_dx[PV] * b_dx[i];
        c_pyy[i] <= b_dy[PV] * b_dy[i];
        c_pxy[i] <= b_dx[PV] * b_dy[i];
        c_pyx[i] <= b_dy[PV] * b_dx[i];
        c_zero[i] <= (b_dx[i] == '0) && (b_dy[i] == '0);
        d_sumsq[i] <= SUMSQ_W'(unsigned'(c_sqx[i])) + SUMSQ_W'(unsigned'(c_sqy[i]));
        d_dot[i] <= -(DOT_W'(c_pxx[i]) + DOT_W'(c_pyy[i]));
        d_crs[i] <= DOT_W'(c_pyx[i]) - DOT_W'(c_pxy[i]);
        d_amask[i] <= c_zero[i] | c_zero[PV];
        ang_dl[1] <= ang;
        for (int k = 2; k <= ANG_DLY; k++) begin
          ang_dl[k] <= ang_dl[k-1];
        end
        mask_dl[1] <= d_amask[i];
        for (int k = 2; k <= SQRT_LAT; k++) begin
          mask_dl[k] <= mask_dl[k-1];
        end
      end
    end

    qapa_sqrt u_sqrt (
      .clk   (clk),
      .en    (en),
      .sumsq (d_sumsq[i]),
      .root  (root[i])
    );

    qapa_cordic u_cordic (
      .clk   (clk),
      .en    (en),
      .dot   (d_dot[i]),
      .crs   (d_crs[i]),
      .angle (ang)
    );

    assign ang_fin[i] = mask_dl[SQRT_LAT] ? '0 : ang_dl[ANG_DLY];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_area <= area_sum;
      d_area <= c_area;
      d_degen <= |c_zero;
      area_dl[1] <= d_area;
      degen_dl[1] <= d_degen;
      for (int k = 2; k <= SQRT_LAT; k++) begin
        area_dl[k] <= area_dl[k-1];
        degen_dl[k] <= degen_dl[k-1];
      end
      dout.doubled_area <= area_dl[SQRT_LAT];
      dout.degenerate <= degen_dl[SQRT_LAT];
      dout.perimeter_q8 <= PERIM_W'(root[0]) + PERIM_W'(root[1])
                         + PERIM_W'(root[2]) + PERIM_W'(root[3]);
      dout.angle_one_q8 <= ang_fin[0];
      dout.angle_two_q8 <= ang_fin[1];
      dout.angle_three_q8 <= ang_fin[2];
      dout.angle_four_q8 <= ang_fin[3];
    end
  end

  `include "quad_area_perimeter_angles_unit_assert.svh"

  `QAPA_ASSERT_IMPLY(a_ready_follows_out, clk, rst, 1'b1, din.ready == (!dout.valid || dout.ready))
  `QAPA_ASSERT_NEXT(a_accept_enters, clk, rst, din.valid && din.ready, vld[0])
  `QAPA_ASSERT_IMPLY(a_degen_angles, clk, rst, dout.valid && dout.degenerate,
    (dout.angle_one_q8 == '0 || dout.angle_three_q8 == '0) && (dout.angle_two_q8 == '0 || dout.angle_four_q8 == '0))
  `QAPA_ASSERT_IMPLY(a_angle_range, clk, rst, dout.valid,
    dout.angle_one_q8 <= ANGLE_W'(ANGLE_MAX) && dout.angle_four_q8 <= ANGLE_W'(ANGLE_MAX))
endmodule
`default_nettype wire

[src/qapa_sqrt.sv]
// Pipelined rounded square root of a side length squared, in Q.8.
`default_nettype none
module qapa_sqrt (
  input  logic                            clk,
  input  logic                            en,
  input  logic [qapa_pkg::SUMSQ_W-1:0]    sumsq,
  output logic [qapa_pkg::ROOT_W-1:0]     root
);
  import qapa_pkg::*;

  logic [SQ_IN_W-1:0] op_in;
  logic [SQ_IN_W-1:0] op_r [1:SQRT_STEPS-1];
  logic [REM_W-1:0] rem_r [1:SQRT_STEPS];
  logic [ROOT_W-1:0] q_r [1:SQRT_STEPS];

  assign op_in = {sumsq, (2 * FRAC_BITS)'(0)};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [SQ_IN_W-1:0] op_cur;
    logic [REM_W-1:0] rem_cur, cur, trial;
    logic [ROOT_W-1:0] q_cur;
    logic ge;
    if (k == 0) begin : g_first
      assign op_cur = op_in;
      assign rem_cur = '0;
      assign q_cur = '0;
    end else begin : g_rest
      assign op_cur = op_r[k];
      assign rem_cur = rem_r[k];
      assign q_cur = q_r[k];
    end
    assign cur = {rem_cur[REM_W-3:0], op_cur[SQ_IN_W-1 -: 2]};
    assign trial = REM_W'({q_cur, 2'b01});
    assign ge = (cur >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? cur - trial : cur;
        q_r[k+1] <= {q_cur[ROOT_W-2:0], ge};
      end
    end
    if (k < SQRT_STEPS - 1) begin : g_op
      always_ff @(posedge clk) begin
        if (en) begin
          op_r[k+1] <= op_cur << 2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root <= q_r[SQRT_STEPS] + ROOT_W'(rem_r[SQRT_STEPS] > REM_W'(q_r[SQRT_STEPS]));
    end
  end
endmodule
`default_nettype wire

[src/qapa_cordic.sv]
// Pipelined vectoring rotator that turns a dot and cross product into an angle.
`default_nettype none
module qapa_cordic (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [qapa_pkg::DOT_W-1:0]   dot,
  input  logic signed [qapa_pkg::DOT_W-1:0]   crs,
  output logic [qapa_pkg::ANGLE_W-1:0]        angle
);
  import qapa_pkg::*;

  function automatic logic signed [CV_W-1:0] shr_tz(input logic signed [CV_W-1:0] v,
                                                    input int unsigned s);
    logic signed [CV_W-1:0] mag;
    mag = (v < 0) ? -v : v;
    mag = mag >> s;
    return (v < 0) ? -mag : mag;
  endfunction

  logic signed [DOT_W-1:0] ay, x0, y0;
  logic signed [CV_W-1:0] x_r [0:CORDIC_N];
  logic signed [CV_W-1:0] y_r [0:CORDIC_N];
  logic signed [Z_W-1:0] z_r [0:CORDIC_N];
  logic signed [Z_W-1:0] z_rnd;
  logic [Z_W-1:0] z_sh;

  assign ay = (crs < 0) ? -crs : crs;
  assign x0 = (dot < 0) ? ay : dot;
  assign y0 = (dot < 0) ? -dot : ay;

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CV_W'(x0) <<< PRESCALE;
      y_r[0] <= CV_W'(y0) <<< PRESCALE;
      z_r[0] <= (dot < 0) ? Z_W'(90 << ANG_FRAC) : '0;
    end
  end

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_iter
    logic signed [CV_W-1:0] dx, dy;
    assign dx = shr_tz(x_r[i], i);
    assign dy = shr_tz(y_r[i], i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          z_r[i+1] <= z_r[i] + atan_q16(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          z_r[i+1] <= z_r[i] - atan_q16(5'(i));
        end
      end
    end
  end

  assign z_rnd = z_r[CORDIC_N] + Z_W'(1 << (ANG_FRAC - FRAC_BITS - 1));
  assign z_sh = (z_rnd < 0) ? '0 : Z_W'(z_rnd >>> (ANG_FRAC - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= (z_sh > Z_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : ANGLE_W'(z_sh);
    end
  end
endmodule
`default_nettype wire
